### hdl/drt_pkg.sv
// Shared types, codes and rectangle helpers for the dirty rectangle tracker.
package drt_pkg;

    // Item kind codes as they arrive on the input channel.
    localparam logic [1:0] KIND_MARK  = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_FULL  = 2'd3;

    typedef enum logic [1:0] {
        OP_MARK,
        OP_QUERY,
        OP_CLEAR,
        OP_FULL
    } t_op;

    typedef struct packed {
        logic        [1:0]  kind;
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
    } t_in_item;

    typedef struct packed {
        logic       repaint_needed;
        logic       full_flag;
        logic [4:0] region_count;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
    } t_rect;

    localparam int RECT_W = $bits(t_rect);

    // Classified command handed from the front to the engine.
    typedef struct packed {
        t_op   op;
        t_rect rect;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_Q_CMP,
        ST_M_UNION,
        ST_M_AREA,
        ST_M_TEST,
        ST_APPEND,
        ST_C_START,
        ST_C_LDA,
        ST_C_CMP,
        ST_C_SHR,
        ST_C_SHW,
        ST_C_END,
        ST_DONE
    } t_state;

    // Bounding union of two rectangles.
    function automatic t_rect rect_union(input t_rect a, input t_rect b);
        t_rect u;
        u.x0 = (a.x0 < b.x0) ? a.x0 : b.x0;
        u.y0 = (a.y0 < b.y0) ? a.y0 : b.y0;
        u.x1 = (a.x1 > b.x1) ? a.x1 : b.x1;
        u.y1 = (a.y1 > b.y1) ? a.y1 : b.y1;
        return u;
    endfunction

    // Overlap test where touching edges count as overlap.
    function automatic logic rect_meets(input t_rect a, input t_rect b);
        return !((b.x1 < a.x0) || (b.x0 > a.x1) || (b.y1 < a.y0) || (b.y0 > a.y1));
    endfunction

endpackage

### hdl/dirty_rectangle_tracker.sv
// Top level of the dirty rectangle tracker: input queue plus merge engine.
//
//  channel | direction | handshake                      | payload
//  in      | input     | i_in_valid / o_in_stall        | i_in_data (t_in_item)
//  out     | output    | o_out_valid / i_out_stall      | o_out_data (t_out_item)
//
// Items are worked on one at a time by a state sequencer around one store RAM.
// Clear and full empty the list; a query compares its rectangle with each stored one.
// A mark walks the list testing each stored rectangle for a merge, then each consolidation
// pass compares pairs of stored rectangles and moves entries down the store after a merge.
// Reset empties the list and sets the full-repaint flag; no clearing pass runs.
// A two-entry queue takes items while the engine waits on a stalled result, until it is full.
module dirty_rectangle_tracker
    import drt_pkg::*;
#(
    parameter int MAX_REGIONS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    // Accept and classify.
    drt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Carry out each command.
    drt_engine #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

### hdl/drt_ram.sv
// Generic single write port, single read port RAM with registered read data.
module drt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 17
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/drt_front.sv
// Input side: accepts items, classifies them and queues them for the engine.
module drt_front
    import drt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_data,
    output logic     o_in_stall,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_fill, n_fill;
    t_cmd       w_cmd;
    logic       w_push;

    // Decode the item kind into an engine operation.
    always_comb begin
        w_cmd.rect.x0 = i_in_data.left;
        w_cmd.rect.y0 = i_in_data.top;
        w_cmd.rect.x1 = i_in_data.right;
        w_cmd.rect.y1 = i_in_data.bottom;
        case (i_in_data.kind)
            KIND_MARK:  w_cmd.op = OP_MARK;
            KIND_QUERY: w_cmd.op = OP_QUERY;
            KIND_CLEAR: w_cmd.op = OP_CLEAR;
            KIND_FULL:  w_cmd.op = OP_FULL;
            default:    w_cmd.op = OP_MARK;
        endcase
    end

    assign o_in_stall  = (r_fill == 2'd2);
    assign w_push      = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // Queue pointers and fill level.
    always_comb begin
        n_wp   = r_wp ^ w_push;
        n_rp   = r_rp ^ i_cmd_pop;
        n_fill = r_fill + {1'b0, w_push} - {1'b0, i_cmd_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_fill <= n_fill;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

### hdl/drt_engine.sv
// Back end: walks the rectangle list, merges, consolidates and answers queries.
module drt_engine
    import drt_pkg::*;
#(
    parameter int MAX_REGIONS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    localparam int DEPTH = MAX_REGIONS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_REGIONS + 2);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_full, n_full;
    logic [CW-1:0]       r_i, n_i;
    logic [CW-1:0]       r_j, n_j;
    logic [CW-1:0]       r_k, n_k;
    t_op                 r_op, n_op;
    t_rect               r_rect, n_rect;
    t_rect               r_a, n_a;
    t_rect               r_b, n_b;
    t_rect               r_u, n_u;
    logic signed [33:0]  r_ua, n_ua;
    logic signed [33:0]  r_ab, n_ab;
    logic signed [33:0]  r_ar, n_ar;
    logic                r_ans, n_ans;
    logic                r_ovalid, n_ovalid;
    t_out_item           r_out, n_out;

    logic                ram_we;
    logic [CW-1:0]       ram_waddr;
    t_rect               ram_wdata;
    logic [CW-1:0]       ram_raddr;
    logic [RECT_W-1:0]   ram_rdata;
    t_rect               rd_rect;

    t_rect               mul_rect;
    logic signed [16:0]  mul_w, mul_h;
    logic signed [33:0]  mul_p;
    logic signed [34:0]  sum_area;
    logic signed [37:0]  lhs, rhs;
    logic                merge_ok;
    logic                out_free;
    t_rect               c_union;

    drt_ram #(
        .WIDTH (RECT_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_rect  = t_rect'(ram_rdata);
    assign out_free = !r_ovalid || !i_out_stall;
    assign c_union  = rect_union(r_a, rd_rect);

    // Shared area multiplier; operands chosen by state.
    always_comb begin
        case (r_state)
            ST_DISPATCH: mul_rect = r_rect;
            ST_M_UNION:  mul_rect = rect_union(rd_rect, r_rect);
            default:     mul_rect = r_b;
        endcase
        mul_w = 17'(mul_rect.x1) - 17'(mul_rect.x0);
        mul_h = 17'(mul_rect.y1) - 17'(mul_rect.y0);
        mul_p = 34'(mul_w) * 34'(mul_h);
    end

    // Merge test: union area * 2 below summed area * 3.
    always_comb begin
        sum_area = 35'(r_ab) + 35'(r_ar);
        lhs      = 38'(r_ua) <<< 1;
        rhs      = (38'(sum_area) <<< 1) + 38'(sum_area);
        merge_ok = (lhs < rhs);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) n_state = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                case (r_op)
                    OP_MARK: begin
                        if (r_full)               n_state = ST_DONE;
                        else if (r_cnt == '0)     n_state = ST_APPEND;
                        else                      n_state = ST_M_UNION;
                    end
                    OP_QUERY: begin
                        if (r_full || r_cnt == '0) n_state = ST_DONE;
                        else                       n_state = ST_Q_CMP;
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_Q_CMP: begin
                if (!(r_i + 1'b1 < r_cnt)) n_state = ST_DONE;
            end
            ST_M_UNION: n_state = ST_M_AREA;
            ST_M_AREA:  n_state = ST_M_TEST;
            ST_M_TEST: begin
                if (merge_ok)               n_state = ST_C_START;
                else if (r_i + 1'b1 < r_cnt) n_state = ST_M_UNION;
                else                        n_state = ST_APPEND;
            end
            ST_APPEND:  n_state = ST_C_START;
            ST_C_START: begin
                if (r_cnt <= CW'(1)) n_state = ST_C_END;
                else                 n_state = ST_C_LDA;
            end
            ST_C_LDA: n_state = ST_C_CMP;
            ST_C_CMP: begin
                if (rect_meets(r_a, rd_rect))  n_state = ST_C_SHR;
                else if (r_j + 1'b1 < r_cnt)   n_state = ST_C_CMP;
                else if (r_i + CW'(2) < r_cnt) n_state = ST_C_LDA;
                else                           n_state = ST_C_END;
            end
            ST_C_SHR: begin
                if (r_k + 1'b1 < r_cnt) n_state = ST_C_SHW;
                else                    n_state = ST_C_START;
            end
            ST_C_SHW: n_state = ST_C_SHR;
            ST_C_END: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath, memory controls and result.
    always_comb begin
        n_cnt     = r_cnt;
        n_full    = r_full;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_op      = r_op;
        n_rect    = r_rect;
        n_a       = r_a;
        n_b       = r_b;
        n_u       = r_u;
        n_ua      = r_ua;
        n_ab      = r_ab;
        n_ar      = r_ar;
        n_ans     = r_ans;
        n_ovalid  = r_ovalid && i_out_stall;
        n_out     = r_out;
        o_cmd_pop = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_i;
        ram_wdata = r_u;
        ram_raddr = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_op      = i_cmd.op;
                    n_rect    = i_cmd.rect;
                end
            end
            ST_DISPATCH: begin
                n_i   = '0;
                n_ans = 1'b0;
                n_ar  = mul_p;
                case (r_op)
                    OP_QUERY: n_ans = r_full;
                    OP_CLEAR: begin
                        n_full = 1'b0;
                        n_cnt  = '0;
                    end
                    OP_FULL: begin
                        n_full = 1'b1;
                        n_cnt  = '0;
                    end
                    default: ;
                endcase
            end
            ST_Q_CMP: begin
                if (rect_meets(rd_rect, r_rect)) n_ans = 1'b1;
                n_i       = r_i + 1'b1;
                ram_raddr = r_i + 1'b1;
            end
            ST_M_UNION: begin
                n_b  = rd_rect;
                n_u  = rect_union(rd_rect, r_rect);
                n_ua = mul_p;
            end
            ST_M_AREA: n_ab = mul_p;
            ST_M_TEST: begin
                if (merge_ok) begin
                    ram_we = 1'b1;
                end else begin
                    n_i       = r_i + 1'b1;
                    ram_raddr = r_i + 1'b1;
                end
            end
            ST_APPEND: begin
                if (r_cnt <= CW'(MAX_REGIONS)) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cnt;
                    ram_wdata = r_rect;
                    n_cnt     = r_cnt + 1'b1;
                end
            end
            ST_C_START: n_i = '0;
            ST_C_LDA: begin
                n_a       = rd_rect;
                n_j       = r_i + 1'b1;
                ram_raddr = r_i + 1'b1;
            end
            ST_C_CMP: begin
                if (rect_meets(r_a, rd_rect)) begin
                    n_a       = c_union;
                    ram_we    = 1'b1;
                    ram_wdata = c_union;
                    n_k       = r_j;
                end else if (r_j + 1'b1 < r_cnt) begin
                    n_j       = r_j + 1'b1;
                    ram_raddr = r_j + 1'b1;
                end else begin
                    n_i       = r_i + 1'b1;
                    ram_raddr = r_i + 1'b1;
                end
            end
            ST_C_SHR: begin
                ram_raddr = r_k + 1'b1;
                if (!(r_k + 1'b1 < r_cnt)) n_cnt = r_cnt - 1'b1;
            end
            ST_C_SHW: begin
                ram_we    = 1'b1;
                ram_waddr = r_k;
                ram_wdata = rd_rect;
                n_k       = r_k + 1'b1;
            end
            ST_C_END: begin
                if (r_cnt > CW'(MAX_REGIONS)) begin
                    n_full = 1'b1;
                    n_cnt  = '0;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_ovalid             = 1'b1;
                    n_out.repaint_needed = r_ans;
                    n_out.full_flag      = r_full;
                    n_out.region_count   = 5'(r_cnt);
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_full   <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_full   <= n_full;
            r_ovalid <= n_ovalid;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_k    <= n_k;
        r_op   <= n_op;
        r_rect <= n_rect;
        r_a    <= n_a;
        r_b    <= n_b;
        r_u    <= n_u;
        r_ua   <= n_ua;
        r_ab   <= n_ab;
        r_ar   <= n_ar;
        r_ans  <= n_ans;
        r_out  <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    // The list never holds more than one entry beyond its limit.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_REGIONS + 1))
        else $error("region count beyond limit");

    // A set full-repaint flag always goes with an empty list.
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_cnt == '0))
        else $error("full flag with stored regions");

    // The store is written only while an item is being worked on.
    a_idle_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_DONE) |-> !ram_we)
        else $error("store write outside item processing");

    // A loaded result carries the count the engine finished with.
    a_result_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> (r_out.region_count == 5'($past(r_cnt))))
        else $error("result count mismatch");
`endif

endmodule
